// ----- hw/rtl/ctc_pkg.sv -----
// shared types and constants for the ctc greedy label decoder
// no dependencies

package ctc_pkg;

    localparam int MAX_CHARS = 256;
    localparam int ADDR_W    = $clog2(MAX_CHARS);
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int ENTRY_W   = 35;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_CHAR   = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
        logic        ends;
    } job_t;

endpackage

// ----- hw/rtl/ctc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies

module ctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ctc_front.sv -----
// front end: takes input words, builds the character table, classifies decode indices
// depends on ctc_pkg and ctc_ram

module ctc_front import ctc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_acc,
    input  logic [1:0]        opcode,
    input  logic [7:0]        char_byte,
    input  logic signed [31:0] label_index,
    input  logic              last_index,
    input  logic              seg_len_we,
    input  logic [15:0]       seg_len,
    input  logic [QCNT_W-1:0] q_count,
    output logic              full,
    output logic              q_push,
    output job_t              q_job
);

    logic [CNT_W-1:0]   table_count_reg, table_count_next;
    logic [23:0]        asm_bytes_reg, asm_bytes_next;
    logic [2:0]         asm_need_reg, asm_need_next;
    logic [1:0]         asm_have_reg, asm_have_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [31:0]        prev_label_reg, prev_label_next;
    logic [15:0]        seg_pos_reg, seg_pos_next;
    logic [15:0]        seg_len_reg;
    logic               s1_v_reg, s1_v_next;
    logic               s1_emit_reg, s1_emit_next;
    logic               s1_ends_reg, s1_ends_next;

    logic               we;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [31:0]        word;
    logic [2:0]         have_inc;
    logic [2:0]         lead_len;
    logic [31:0]        idx;
    logic               repeated;
    logic               emit;
    logic [15:0]        npos;
    logic               ends;
    logic               room;
    logic [2:0]         rlen;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd1;
        if ((b & 8'h80) == 8'h00)
        begin
            len = 3'd1;
        end
        else if ((b & 8'hE0) == 8'hC0)
        begin
            len = 3'd2;
        end
        else if ((b & 8'hF0) == 8'hE0)
        begin
            len = 3'd3;
        end
        else if ((b & 8'hF8) == 8'hF0)
        begin
            len = 3'd4;
        end
        return len;
    endfunction

    ctc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CHARS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (table_count_reg[ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (idx[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        idx      = label_index;
        lead_len = lead_length(char_byte);
        word     = {8'h00, asm_bytes_reg} | ({24'h000000, char_byte} << {asm_have_reg, 3'b000});
        have_inc = {1'b0, asm_have_reg} + 3'd1;
        room     = table_count_reg != CNT_W'(MAX_CHARS);
        repeated = prev_valid_reg && (prev_label_reg == idx);
        emit     = !repeated && (idx != 32'd0) && !idx[31] && (idx < 32'(table_count_reg));
        npos     = seg_pos_reg + 16'd1;
        ends     = (npos == seg_len_reg) || last_index;

        table_count_next = table_count_reg;
        asm_bytes_next   = asm_bytes_reg;
        asm_need_next    = asm_need_reg;
        asm_have_next    = asm_have_reg;
        prev_valid_next  = prev_valid_reg;
        prev_label_next  = prev_label_reg;
        seg_pos_next     = seg_pos_reg;
        s1_v_next        = 1'b0;
        s1_emit_next     = emit;
        s1_ends_next     = ends;
        we               = 1'b0;
        wdata            = {3'd1, 24'h000000, char_byte};

        if (in_acc)
        begin
            case (opcode)
                OP_CLEAR:
                begin
                    table_count_next = CNT_W'(1);
                    asm_bytes_next   = 24'h000000;
                    asm_need_next    = 3'd0;
                    asm_have_next    = 2'd0;
                end
                OP_CHAR:
                begin
                    if (asm_need_reg == 3'd0)
                    begin
                        if (lead_len == 3'd1)
                        begin
                            we = room;
                        end
                        else
                        begin
                            asm_need_next  = lead_len;
                            asm_have_next  = 2'd1;
                            asm_bytes_next = {16'h0000, char_byte};
                        end
                    end
                    else if (have_inc >= asm_need_reg)
                    begin
                        we             = room;
                        wdata          = {asm_need_reg, word};
                        asm_bytes_next = 24'h000000;
                        asm_need_next  = 3'd0;
                        asm_have_next  = 2'd0;
                    end
                    else
                    begin
                        asm_bytes_next = word[23:0];
                        asm_have_next  = have_inc[1:0];
                    end
                    if (we)
                    begin
                        table_count_next = table_count_reg + CNT_W'(1);
                    end
                end
                OP_DECODE:
                begin
                    s1_v_next = emit || ends;
                    if (ends)
                    begin
                        seg_pos_next    = 16'd0;
                        prev_valid_next = 1'b0;
                        prev_label_next = 32'd0;
                    end
                    else
                    begin
                        seg_pos_next    = npos;
                        prev_valid_next = 1'b1;
                        prev_label_next = idx;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_count_reg <= CNT_W'(1);
            asm_bytes_reg   <= 24'h000000;
            asm_need_reg    <= 3'd0;
            asm_have_reg    <= 2'd0;
            prev_valid_reg  <= 1'b0;
            prev_label_reg  <= 32'd0;
            seg_pos_reg     <= 16'd0;
            seg_len_reg     <= 16'd128;
            s1_v_reg        <= 1'b0;
        end
        else
        begin
            table_count_reg <= table_count_next;
            asm_bytes_reg   <= asm_bytes_next;
            asm_need_reg    <= asm_need_next;
            asm_have_reg    <= asm_have_next;
            prev_valid_reg  <= prev_valid_next;
            prev_label_reg  <= prev_label_next;
            seg_pos_reg     <= seg_pos_next;
            s1_v_reg        <= s1_v_next;
            if (seg_len_we)
            begin
                seg_len_reg <= seg_len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_emit_reg <= s1_emit_next;
        s1_ends_reg <= s1_ends_next;
    end

    always_comb
    begin
        rlen        = (rdata[34:32] > 3'd4) ? 3'd4 : rdata[34:32];
        q_push      = s1_v_reg;
        q_job.bytes = rdata[31:0];
        q_job.len   = s1_emit_reg ? rlen : 3'd0;
        q_job.ends  = s1_ends_reg;
    end

    assign full = (q_count + QCNT_W'(s1_v_reg)) >= QCNT_W'(QDEPTH);

endmodule

// ----- hw/rtl/ctc_fifo.sv -----
// short job queue between front and back ends
// depends on ctc_pkg

module ctc_fifo import ctc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  job_t              din,
    input  logic              pop,
    output job_t              dout,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = count_reg == '0;
    assign count = count_reg;

endmodule

// ----- hw/rtl/ctc_back.sv -----
// back end: expands queued jobs into output bytes and end markers
// depends on ctc_pkg

module ctc_back import ctc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_job,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       end_of_text,
    output logic       last
);

    job_t       job_reg, job_next;
    logic       job_v_reg, job_v_next;
    logic [1:0] job_i_reg, job_i_next;
    logic       out_v_reg, out_v_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_bv_reg, out_bv_next;
    logic       out_eot_reg, out_eot_next;
    logic       out_last_reg, out_last_next;

    logic       load;
    logic       final_byte;
    logic       job_done;
    logic [31:0] shifted;

    always_comb
    begin
        load       = !out_v_reg || pop;
        shifted    = job_reg.bytes >> {job_i_reg, 3'b000};
        final_byte = ({1'b0, job_i_reg} + 3'd1) == job_reg.len;

        out_v_next    = out_v_reg;
        out_byte_next = out_byte_reg;
        out_bv_next   = out_bv_reg;
        out_eot_next  = out_eot_reg;
        out_last_next = out_last_reg;
        job_i_next    = job_i_reg;
        job_done      = 1'b0;

        if (load)
        begin
            out_v_next = job_v_reg;
            if (job_reg.len == 3'd0)
            begin
                // end marker for a segment end that emits no character
                out_byte_next = 8'h00;
                out_bv_next   = 1'b0;
                out_eot_next  = 1'b1;
                out_last_next = 1'b1;
                job_done      = job_v_reg;
            end
            else
            begin
                out_byte_next = shifted[7:0];
                out_bv_next   = 1'b1;
                out_eot_next  = final_byte && job_reg.ends;
                out_last_next = final_byte;
                job_done      = job_v_reg && final_byte;
                if (job_v_reg && !final_byte)
                begin
                    job_i_next = job_i_reg + 2'd1;
                end
            end
        end

        q_pop      = (!job_v_reg || job_done) && !q_empty;
        job_v_next = job_v_reg && !job_done;
        job_next   = job_reg;
        if (q_pop)
        begin
            job_v_next = 1'b1;
            job_next   = q_job;
            job_i_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
            job_i_reg <= 2'd0;
        end
        else
        begin
            job_v_reg <= job_v_next;
            out_v_reg <= out_v_next;
            job_i_reg <= job_i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_byte_reg <= out_byte_next;
        out_bv_reg   <= out_bv_next;
        out_eot_reg  <= out_eot_next;
        out_last_reg <= out_last_next;
    end

    assign empty       = !out_v_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = out_bv_reg;
    assign end_of_text = out_eot_reg;
    assign last        = out_last_reg;

endmodule

// ----- hw/rtl/ctc_greedy_label_decoder.sv -----
// top level of the ctc greedy label decoder: front end, job queue, back end
// depends on ctc_pkg, ctc_front, ctc_fifo and ctc_back
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------------
//   input    | push / full      | opcode, char_byte, label_index, last_index
//   result   | empty / pop      | out_byte, byte_valid, end_of_text, last
//   config   | seg_len_we       | seg_len
//
// one input word per cycle enters while full is low; each result word leaves on a pop,
// so an emitted decode index gives as many result words as its character has bytes
// (1 to 4), and a segment end that emits nothing gives one end marker. the first result
// passes the table read register, then the queue, the job register and the output register.
// reset empties the character table through its fill count; no clearing pass.
// full rises when the four-entry job queue, counting the word in the read stage,
// has no room; pop held low stalls the back end and, once the queue fills, the input.

module ctc_greedy_label_decoder import ctc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic [7:0]         char_byte,
    input  logic signed [31:0] label_index,
    input  logic               last_index,
    input  logic               seg_len_we,
    input  logic [15:0]        seg_len,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               end_of_text,
    output logic               last
);

    logic              in_acc;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;
    job_t              q_din;
    job_t              q_dout;

    assign in_acc = push && !full;

    ctc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_acc      (in_acc),
        .opcode      (opcode),
        .char_byte   (char_byte),
        .label_index (label_index),
        .last_index  (last_index),
        .seg_len_we  (seg_len_we),
        .seg_len     (seg_len),
        .q_count     (q_count),
        .full        (full),
        .q_push      (q_push),
        .q_job       (q_din)
    );

    ctc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .count (q_count)
    );

    ctc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_job       (q_dout),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .end_of_text (end_of_text),
        .last        (last)
    );

endmodule

// ----- dv/ctc_greedy_label_decoder_tb.sv -----
// testbench for ctc_greedy_label_decoder: queued stimulus, an in-line decoder model and a
// scoreboard of expected text words, checked word by word at the result port
// depends on ctc_pkg and the ctc_greedy_label_decoder rtl

module ctc_greedy_label_decoder_tb;
    import ctc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  chr;
        logic [31:0] idx;
        logic        fin;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_text;
        logic       last;
    } text_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         opcode = OP_CLEAR;
    logic [7:0]         char_byte = 8'd0;
    logic [31:0]        label_index = 32'd0;
    logic               last_index = 1'b0;
    logic               seg_len_we = 1'b0;
    logic [15:0]        seg_len = 16'd0;
    logic               empty;
    logic               pop = 1'b0;
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               end_of_text;
    logic               last;

    in_word_t   word_q[$];
    text_word_t text_q[$];
    in_word_t   nxt_word;
    text_word_t got;
    text_word_t want;
    logic       word_taken = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int bad_words = 0;
    int words_in = 0;
    int words_out = 0;
    int n_settings = 0;

    logic [ENTRY_W-1:0] tbl_entry [MAX_CHARS];
    logic [CNT_W-1:0]   tbl_fill = CNT_W'(1);
    logic [23:0]        pend_bytes = 24'd0;
    logic [2:0]         pend_need = 3'd0;
    logic [1:0]         pend_have = 2'd0;
    logic               prev_seen = 1'b0;
    logic [31:0]        prev_idx = 32'd0;
    logic [15:0]        seg_pos = 16'd0;
    logic [15:0]        cfg_seg_len = 16'd128;

    ctc_greedy_label_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .char_byte   (char_byte),
        .label_index (label_index),
        .last_index  (last_index),
        .seg_len_we  (seg_len_we),
        .seg_len     (seg_len),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .end_of_text (end_of_text),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void store_char(logic [31:0] bytes, logic [2:0] len);
        if (tbl_fill < CNT_W'(MAX_CHARS))
        begin
            tbl_entry[tbl_fill[ADDR_W-1:0]] = {len, bytes};
            tbl_fill = tbl_fill + 1'b1;
        end
    endfunction

    function automatic void predict_text(logic [1:0] op, logic [7:0] b, logic [31:0] idx,
                                         logic fin);
        logic [2:0]         need;
        logic [2:0]         nhave;
        logic [31:0]        acc;
        logic [15:0]        npos;
        logic [ENTRY_W-1:0] ent;
        logic [2:0]         len;
        logic               ends;
        logic               emit;
        text_word_t         w;
        int                 n;
        n = 0;
        case (op)
            OP_CLEAR:
            begin
                tbl_fill = CNT_W'(1);
                pend_bytes = 24'd0;
                pend_need = 3'd0;
                pend_have = 2'd0;
            end
            OP_CHAR:
            begin
                if (pend_need == 3'd0)
                begin
                    casez (b)
                        8'b0???????: need = 3'd1;
                        8'b110?????: need = 3'd2;
                        8'b1110????: need = 3'd3;
                        8'b11110???: need = 3'd4;
                        default:     need = 3'd1;
                    endcase
                    if (need == 3'd1)
                        store_char({24'd0, b}, 3'd1);
                    else
                    begin
                        pend_need = need;
                        pend_have = 2'd1;
                        pend_bytes = {16'd0, b};
                    end
                end
                else
                begin
                    acc = {8'd0, pend_bytes} | ({24'd0, b} << (8 * pend_have));
                    nhave = {1'b0, pend_have} + 3'd1;
                    if (nhave >= pend_need)
                    begin
                        store_char(acc, pend_need);
                        pend_bytes = 24'd0;
                        pend_need = 3'd0;
                        pend_have = 2'd0;
                    end
                    else
                    begin
                        pend_bytes = acc[23:0];
                        pend_have = nhave[1:0];
                    end
                end
            end
            OP_DECODE:
            begin
                emit = !(prev_seen && prev_idx == idx) && idx != 32'd0 && !idx[31] &&
                       idx < tbl_fill;
                npos = seg_pos + 16'd1;
                ends = (npos == cfg_seg_len) || fin;
                prev_seen = 1'b1;
                prev_idx = idx;
                if (emit)
                begin
                    ent = tbl_entry[idx[ADDR_W-1:0]];
                    len = (ent[34:32] > 3'd4) ? 3'd4 : ent[34:32];
                    for (int i = 0; i < len; i++)
                    begin
                        w.out_byte = ent[8*i +: 8];
                        w.byte_valid = 1'b1;
                        w.last = (i + 1 == len);
                        w.end_of_text = w.last && ends;
                        text_q.insert(text_q.size(), w);
                        n++;
                    end
                end
                if (ends)
                begin
                    if (n == 0)
                    begin
                        w = {8'd0, 1'b0, 1'b1, 1'b1};
                        text_q.insert(text_q.size(), w);
                    end
                    seg_pos = 16'd0;
                    prev_seen = 1'b0;
                    prev_idx = 32'd0;
                end
                else
                    seg_pos = npos;
            end
            default: ;
        endcase
    endfunction

    // monitor: check the result port first, then take in the accepted input word
    always @(posedge clk)
    begin
        word_taken = rst_n && push && !full;
        if (rst_n && pop && !empty)
        begin
            got = {out_byte, byte_valid, end_of_text, last};
            words_out++;
            if (text_q.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected word: byte %02h valid %b eot %b last %b",
                             got.out_byte, got.byte_valid, got.end_of_text, got.last);
            end
            else
            begin
                want = text_q.pop_front();
                if (got !== want)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("mismatch: exp byte %02h valid %b eot %b last %b, got %02h %b %b %b",
                                 want.out_byte, want.byte_valid, want.end_of_text, want.last,
                                 got.out_byte, got.byte_valid, got.end_of_text, got.last);
                end
            end
        end
        if (word_taken)
        begin
            words_in++;
            predict_text(opcode, char_byte, label_index, last_index);
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (!push || word_taken)
        begin
            if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt_word = word_q.pop_front();
                push <= 1'b1;
                opcode <= nxt_word.op;
                char_byte <= nxt_word.chr;
                label_index <= nxt_word.idx;
                last_index <= nxt_word.fin;
            end
            else
                push <= 1'b0;
        end
    end

    // receiver with long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void add_word(logic [1:0] op, logic [7:0] b, logic [31:0] idx,
                                     logic fin);
        in_word_t w;
        w = {op, b, idx, fin};
        word_q.insert(word_q.size(), w);
    endfunction

    // clear, load n_chars characters, then decode n_dec indices
    function automatic void gen_session(int n_chars, int n_dec, int multi_pct);
        int          cnt;
        int          len;
        logic [7:0]  lead;
        logic [31:0] idx;
        idx = 32'd0;
        cnt = 1;
        add_word(OP_CLEAR, 8'($urandom), $urandom, 1'($urandom));
        for (int c = 0; c < n_chars; c++)
        begin
            len = 1;
            lead = 8'($urandom_range(8'h7F));
            if ($urandom_range(99) < multi_pct)
            begin
                len = $urandom_range(5, 2);
                case (len)
                    2: lead = 8'($urandom_range(8'hDF, 8'hC0));
                    3: lead = 8'($urandom_range(8'hEF, 8'hE0));
                    4: lead = 8'($urandom_range(8'hF7, 8'hF0));
                    default:
                    begin
                        len = 1;
                        lead = $urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                                 : 8'($urandom_range(8'hFF, 8'hF8));
                    end
                endcase
            end
            add_word(OP_CHAR, lead, $urandom, 1'($urandom));
            for (int k = 1; k < len; k++)
                add_word(OP_CHAR, ($urandom_range(9) == 0) ? 8'($urandom)
                                  : 8'($urandom_range(8'hBF, 8'h80)), $urandom, 1'($urandom));
            cnt++;
            if ($urandom_range(39) == 0)
                add_word(OP_SPARE, 8'($urandom), $urandom, 1'($urandom));
            // large sessions keep loading so that the table runs full
            if (n_chars < 100 && $urandom_range(59) == 0)
            begin
                add_word(OP_CHAR, 8'($urandom_range(8'hEF, 8'hC0)), $urandom, 1'b0);
                add_word(OP_CLEAR, 8'($urandom), $urandom, 1'($urandom));
                cnt = 1;
            end
        end
        for (int d = 0; d < n_dec; d++)
        begin
            case ($urandom_range(99)) inside
                [0:24]:  ;
                [25:32]: idx = $urandom;
                default: idx = $urandom_range(cnt + 1);
            endcase
            add_word(OP_DECODE, 8'($urandom), idx, $urandom_range(19) == 0);
        end
    endfunction

    task automatic drain();
        while (word_q.size() != 0 || push)
            @(posedge clk);
        while (text_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_seg_len(logic [15:0] v);
        @(negedge clk);
        seg_len_we <= 1'b1;
        seg_len <= v;
        @(negedge clk);
        seg_len_we <= 1'b0;
        cfg_seg_len = v;
        n_settings++;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 66;
        write_seg_len(16'd4);

        add_word(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        add_word(OP_CHAR, 8'h00, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'hC3, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'hA9, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'hE2, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'h82, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'hAC, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'hF0, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'h9F, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'h98, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'h80, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'h80, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'hFF, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'hC2, 32'd0, 1'b0);
        add_word(OP_CHAR, 8'hFF, 32'd0, 1'b0);
        add_word(OP_DECODE, 8'h00, 32'd0, 1'b0);
        add_word(OP_DECODE, 8'h00, 32'd2, 1'b0);
        add_word(OP_DECODE, 8'h00, 32'd2, 1'b0);
        add_word(OP_DECODE, 8'h00, 32'd4, 1'b0);
        add_word(OP_DECODE, 8'h00, 32'd4, 1'b0);
        add_word(OP_DECODE, 8'h00, 32'hFFFF_FFFF, 1'b0);
        add_word(OP_DECODE, 8'h00, 32'd8, 1'b0);
        add_word(OP_DECODE, 8'h00, 32'h7FFF_FFFF, 1'b0);
        add_word(OP_SPARE, 8'h5A, 32'd3, 1'b1);
        add_word(OP_DECODE, 8'h00, 32'd3, 1'b1);
        add_word(OP_CHAR, 8'hE5, 32'd0, 1'b0);
        add_word(OP_CLEAR, 8'h00, 32'd0, 1'b0);
        add_word(OP_DECODE, 8'h00, 32'd1, 1'b1);
        drain();

        write_seg_len(16'd1);
        gen_session(0, 6, 0);
        gen_session(3, 8, 40);
        drain();

        write_seg_len(16'd3);
        @(posedge clk);
        hold_left = 300;
        gen_session(5, 18, 50);
        drain();

        send_idle_pct = 66;
        recv_idle_pct = 6;
        write_seg_len(16'hFFFF);
        gen_session(3, 6, 40);
        drain();

        write_seg_len(16'd0);
        gen_session(3, 6, 60);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seg_len(16'd7);
        gen_session(258, 6, 2);
        drain();

        $display("%0d input words taken under %0d seg_len settings", words_in, n_settings);
        $display("%0d result words checked, %0d bad", words_out, bad_words);
        if (bad_words == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ctc_pkg.sv
hw/rtl/ctc_ram.sv
hw/rtl/ctc_front.sv
hw/rtl/ctc_fifo.sv
hw/rtl/ctc_back.sv
hw/rtl/ctc_greedy_label_decoder.sv
dv/ctc_greedy_label_decoder_tb.sv
